### src/tpq_pkg.sv
// Package for the two-priority FIFO queue: sizes, action and status codes,
// and the control and result structs shared by the cell row and output stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;

    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_POP     = 2'd1;
    localparam logic [1:0] ACT_EXTRACT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NO_HIGH = 2'd3;

    typedef struct packed {
        logic write_en;
        logic pop;
        logic extract;
        logic occupied;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } result_t;

endpackage

`default_nettype wire

### src/tpq_cell.sv
// One slot of the queue's shift chain: holds a value and its priority,
// loads from the tail bus or from its neighbour nearer the tail. Uses tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpq_cell
    import tpq_pkg::*;
(
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic signed [31:0] push_value,
    input  wire logic               push_pri,
    input  wire logic signed [31:0] next_value,
    input  wire logic               next_pri,
    input  wire logic               seen_in,
    output logic                    seen_out,
    output logic signed [31:0]      hit_value,
    output logic signed [31:0]      held_value,
    output logic                    held_pri
);

    logic signed [31:0] value_reg;
    logic               pri_reg;
    logic               own_high;
    logic               hit;
    logic               shift;

    // A cell shifts when it is at or behind the entry being taken out.
    assign own_high   = ctrl.occupied && pri_reg;
    assign hit        = ctrl.extract && own_high && !seen_in;
    assign shift      = ctrl.pop || (ctrl.extract && (seen_in || own_high));
    assign seen_out   = seen_in || own_high;
    assign hit_value  = hit ? value_reg : '0;
    assign held_value = value_reg;
    assign held_pri   = pri_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.write_en)
        begin
            value_reg <= push_value;
            pri_reg   <= push_pri;
        end
        else if (shift)
        begin
            value_reg <= next_value;
            pri_reg   <= next_pri;
        end
    end

endmodule

`default_nettype wire

### src/tpq_out.sv
// Output register with a skid stage for the queue's result words.
// Uses tpq_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module tpq_out
    import tpq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    output logic         busy,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take      = out_valid_reg && !out_stall;
    assign busy      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = load_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = load_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

### src/two_priority_fifo_queue_top.sv
// Two-priority FIFO queue: top level with the cell row, occupancy count and
// status decision. Depends on tpq_pkg, tpq_cell and tpq_out.
//
// Usage. Each request word on the input channel (action, value, priority_req)
// is accepted when in_valid is high and in_stall is low. A push appends the
// value at the tail, a pop takes the head whatever its priority, and an
// extract removes the oldest high-priority entry, the entries behind it each
// moving one cell towards the head in the same cycle.
// Every request gives exactly one result word (status, removed_value, count,
// is_empty) on the output channel, taken when out_valid is high and out_stall
// is low.
// The result word is registered in the output register, or in the skid stage
// while that holds an untaken word. Throughput is one request per cycle while
// in_stall is low; the cells decide locally and the search for the first
// high-priority entry ripples through the CAPACITY-cell row within that cycle.
// When the receiver stalls, the output register holds its word and a skid
// stage takes one more; only when that is full does in_stall rise.
// Reset empties the queue (the count clears) and drops any pending results;
// the cell contents are left as they were and are never read until written.
`timescale 1ns / 1ps
`default_nettype none

module two_priority_fifo_queue_top
    import tpq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic               priority_req,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      removed_value,
    output logic [COUNT_W-1:0]      count,
    output logic                    is_empty
);

    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic             accept;
    logic             empty_now;
    logic             full_now;
    logic             found;
    logic             push_ok;
    logic             pop_ok;
    logic             extract_go;
    logic             busy;
    logic signed [31:0] extract_value;
    result_t          result;
    result_t          out_data;

    cell_ctrl_t         ctrl       [CAPACITY];
    logic signed [31:0] cell_value [CAPACITY];
    logic               cell_pri   [CAPACITY];
    logic signed [31:0] cell_hit   [CAPACITY];
    logic               seen       [CAPACITY+1];

    assign in_stall  = busy;
    assign accept    = in_valid && !busy;
    assign empty_now = (entry_count_reg == '0);
    assign full_now  = (entry_count_reg == CNT_W'(CAPACITY));

    // Commands are broadcast to the row only for an accepted word, so the
    // cells hold still at every other edge.
    assign push_ok    = accept && (action == ACT_PUSH) && !full_now;
    assign pop_ok     = accept && (action == ACT_POP) && !empty_now;
    assign extract_go = accept && (action == ACT_EXTRACT);

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] nb_value;
            logic               nb_pri;

            // The cell nearest the tail shifts in nothing of interest.
            if (gi == CAPACITY - 1)
            begin : g_last
                assign nb_value = '0;
                assign nb_pri   = 1'b0;
            end
            else
            begin : g_mid
                assign nb_value = cell_value[gi+1];
                assign nb_pri   = cell_pri[gi+1];
            end

            assign ctrl[gi].write_en = push_ok && (entry_count_reg == CNT_W'(gi));
            assign ctrl[gi].pop      = pop_ok;
            assign ctrl[gi].extract  = extract_go;
            assign ctrl[gi].occupied = (entry_count_reg > CNT_W'(gi));

            tpq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[gi]),
                .push_value (value),
                .push_pri   (priority_req),
                .next_value (nb_value),
                .next_pri   (nb_pri),
                .seen_in    (seen[gi]),
                .seen_out   (seen[gi+1]),
                .hit_value  (cell_hit[gi]),
                .held_value (cell_value[gi]),
                .held_pri   (cell_pri[gi])
            );
        end
    endgenerate

    assign found = seen[CAPACITY];

    // At most one cell reports a hit, so an OR gathers the removed value.
    always_comb
    begin
        extract_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            extract_value = extract_value | cell_hit[i];
        end
    end

    always_comb
    begin
        entry_count_next     = entry_count_reg;
        result.status        = ST_OK;
        result.removed_value = '0;
        case (action)
            ACT_PUSH:
            begin
                if (full_now)
                    result.status = ST_FULL;
                else
                    entry_count_next = entry_count_reg + CNT_W'(1);
            end
            ACT_POP:
            begin
                if (empty_now)
                    result.status = ST_EMPTY;
                else
                begin
                    result.removed_value = cell_value[0];
                    entry_count_next     = entry_count_reg - CNT_W'(1);
                end
            end
            ACT_EXTRACT:
            begin
                if (empty_now)
                    result.status = ST_EMPTY;
                else if (!found)
                    result.status = ST_NO_HIGH;
                else
                begin
                    result.removed_value = extract_value;
                    entry_count_next     = entry_count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                entry_count_next = entry_count_reg;
            end
        endcase
        result.count    = COUNT_W'(entry_count_next);
        result.is_empty = (entry_count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= '0;
        else if (accept)
            entry_count_reg <= entry_count_next;
    end

    tpq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status        = out_data.status;
    assign removed_value = out_data.removed_value;
    assign count         = out_data.count;
    assign is_empty      = out_data.is_empty;

endmodule

`default_nettype wire

### src/tpq_checker.sv
// Port-level checker for the two-priority FIFO queue, bound to the top level.
// Uses tpq_pkg for the status codes and sizes.
`timescale 1ns / 1ps
`default_nettype none

module tpq_checker
    import tpq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic signed [31:0] removed_value,
    input wire logic [COUNT_W-1:0] count,
    input wire logic               is_empty
);

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // The empty flag agrees with the reported count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)))
        else $error("is_empty disagrees with count");

    // A refused push is only reported with the queue at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
        else $error("full status with queue not at capacity");

    // A refused request, whether a removal or a push, reports nothing removed.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_EMPTY) || (status == ST_NO_HIGH) ||
                      (status == ST_FULL)) |-> (removed_value == '0))
        else $error("refused request reported a removed value");

    // An empty status means the queue is empty afterwards.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> is_empty)
        else $error("empty status with entries held");

endmodule

bind two_priority_fifo_queue_top tpq_checker u_tpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .count         (count),
    .is_empty      (is_empty)
);

`default_nettype wire
